// ===== rtl/core/rcpos_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpos_pkg
// Shared widths, register indexes, item types and the divider step for the
// row/column pixel offset and scale block.
// ----------------------------------------------------------------------------
package rcpos_pkg;

  localparam int TBL_DEPTH  = 4096;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);

  localparam int PIX_W      = 16;
  localparam int COORD_W    = 16;
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 17;
  localparam int ENT_W      = 18;
  localparam int SEL_W      = 17;                 // holds any index and the depth itself
  localparam int FRAC_W     = 10;
  localparam int ROUND      = 1 << (FRAC_W - 1);
  localparam int PROD_W     = ENT_W + PIX_W + 1;
  localparam int SUM_W      = ENT_W + 1;
  localparam int DIV_STAGES = COORD_W;

  localparam int MODE_W     = 2;
  localparam int MODE_COL   = 0;                  // bit: index by column
  localparam int MODE_SCALE = 1;                  // bit: gain instead of offset

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_PITCH  = 3'd6;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;
    logic [PIX_W-1:0] pixel_in;
    logic             in_roi;
  } item_t;

  // restoring divider state: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] dq;
  } div_t;

  function automatic div_t div_step(input div_t cur, input logic [COORD_W-1:0] pitch);
    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    logic             qbit;
    div_t             nxt;
    trial = {cur.rem, cur.dq[COORD_W-1]};
    diff  = trial - {1'b0, pitch};
    qbit  = (trial >= {1'b0, pitch});
    nxt.rem = qbit ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    nxt.dq  = {cur.dq[COORD_W-2:0], qbit};
    return nxt;
  endfunction

endpackage

// ===== rtl/core/row_col_pixel_offset_scale.sv =====
// ----------------------------------------------------------------------------
// row_col_pixel_offset_scale: per-row / per-column raw pixel offset and gain
// Stages from input transfer to result: input stage, 16 divider stages,
//   table read, multiply, round/clamp into the output register. One item per
//   cycle unless m_tready stalls; the 16-stage pitch divider sets the depth.
// Reset (rst, synchronous) clears valid bits and the configuration registers
//   (pitches become one); the table stays undefined until loaded.
// ----------------------------------------------------------------------------
module row_col_pixel_offset_scale import rcpos_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [79:0]          s_tdata,   // entry_index[11:0], entry_value[28:12],
                                          // pixel_row[44:29], pixel_col[60:45],
                                          // pixel_in[76:61], zero pad [79:77]
  input  logic [0:0]           s_tuser,   // func[0]
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // pixel_out[15:0]
  output logic [0:0]           m_tuser,   // corrected[0]
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // tdata field positions
  localparam int IDX_LSB = 0;
  localparam int VAL_LSB = IDX_LSB + IDX_W;
  localparam int ROW_LSB = VAL_LSB + VAL_W;
  localparam int COL_LSB = ROW_LSB + COORD_W;
  localparam int PIX_LSB = COL_LSB + COORD_W;

  // configuration registers
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] roi_top;
  logic [COORD_W-1:0] roi_left;
  logic [COORD_W-1:0] roi_bottom;
  logic [COORD_W-1:0] roi_right;
  logic [COORD_W-1:0] row_pitch;
  logic [COORD_W-1:0] col_pitch;

  logic [COORD_W-1:0] rp_eff;
  logic [COORD_W-1:0] cp_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= '0;
      roi_top    <= '0;
      roi_left   <= '0;
      roi_bottom <= '0;
      roi_right  <= '0;
      row_pitch  <= COORD_W'(1);
      col_pitch  <= COORD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:       mode       <= cfg_data[MODE_W-1:0];
        CFG_ROI_TOP:    roi_top    <= cfg_data;
        CFG_ROI_LEFT:   roi_left   <= cfg_data;
        CFG_ROI_BOTTOM: roi_bottom <= cfg_data;
        CFG_ROI_RIGHT:  roi_right  <= cfg_data;
        CFG_ROW_PITCH:  row_pitch  <= cfg_data;
        CFG_COL_PITCH:  col_pitch  <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero pitch behaves as pitch one
  assign rp_eff = (row_pitch == '0) ? COORD_W'(1) : row_pitch;
  assign cp_eff = (col_pitch == '0) ? COORD_W'(1) : col_pitch;

  // --------------------------------------------------------------------------
  // Input stage: region test and offsets from the region corner. An empty
  // region fails the compares by itself. The offsets only matter in-region,
  // where they cannot wrap.
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] in_row;
  logic [COORD_W-1:0] in_col;
  logic               in_roi;
  item_t              item_in;

  logic               vld0;
  item_t              item0;
  logic [COORD_W-1:0] dr0;
  logic [COORD_W-1:0] dc0;
  logic               ce0;
  logic               div_rdy;

  assign in_row = s_tdata[ROW_LSB +: COORD_W];
  assign in_col = s_tdata[COL_LSB +: COORD_W];
  assign in_roi = (in_row >= roi_top) && (in_row < roi_bottom) &&
                  (in_col >= roi_left) && (in_col < roi_right);

  always_comb begin
    item_in.func        = s_tuser[0];
    item_in.entry_index = s_tdata[IDX_LSB +: IDX_W];
    item_in.entry_value = s_tdata[VAL_LSB +: VAL_W];
    item_in.pixel_in    = s_tdata[PIX_LSB +: PIX_W];
    item_in.in_roi      = in_roi;
  end

  // the input stage moves when empty or when the divider takes its item
  assign ce0      = !vld0 || div_rdy;
  assign s_tready = ce0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (ce0) begin
      vld0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce0) begin
      item0 <= item_in;
      dr0   <= in_row - roi_top;
      dc0   <= in_col - roi_left;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: quotient picks the table entry, remainders give the grid test
  // --------------------------------------------------------------------------
  logic  div_vld;
  logic  corr_rdy;
  item_t div_item;
  div_t  div_row;
  div_t  div_col;

  rcpos_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (vld0),
    .in_rdy    (div_rdy),
    .in_item   (item0),
    .in_row    (dr0),
    .in_col    (dc0),
    .row_pitch (rp_eff),
    .col_pitch (cp_eff),
    .out_vld   (div_vld),
    .out_rdy   (corr_rdy),
    .out_item  (div_item),
    .out_row   (div_row),
    .out_col   (div_col)
  );

  // --------------------------------------------------------------------------
  // Table, correction and output register. Load transfers write the table in
  // stream order and give no result.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] pixel_out;
  logic             corrected;

  rcpos_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_vld    (div_vld),
    .in_rdy    (corr_rdy),
    .in_item   (div_item),
    .in_row    (div_row),
    .in_col    (div_col),
    .out_vld   (m_tvalid),
    .out_rdy   (m_tready),
    .pixel_out (pixel_out),
    .corrected (corrected)
  );

  assign m_tdata    = pixel_out;
  assign m_tuser[0] = corrected;

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !vld0 |-> s_tready)
    else $error("empty input stage refused a transfer");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == CFG_MODE) |=> (mode == $past(cfg_data[MODE_W-1:0])))
    else $error("mode register write lost");

endmodule

// ===== rtl/core/rcpos_div.sv =====
// ----------------------------------------------------------------------------
// rcpos_div
// Pipelined restoring divider, one quotient bit per stage, row and column
// offsets side by side. Stages squeeze out bubbles under back-pressure.
// ----------------------------------------------------------------------------
module rcpos_div import rcpos_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  output logic               in_rdy,
  input  item_t              in_item,
  input  logic [COORD_W-1:0] in_row,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] row_pitch,
  input  logic [COORD_W-1:0] col_pitch,
  output logic               out_vld,
  input  logic               out_rdy,
  output item_t              out_item,
  output div_t               out_row,
  output div_t               out_col
);

  logic  vld     [DIV_STAGES];
  item_t st_item [DIV_STAGES];
  div_t  st_row  [DIV_STAGES];
  div_t  st_col  [DIV_STAGES];
  div_t  row_next[DIV_STAGES];
  div_t  col_next[DIV_STAGES];
  logic  ce      [DIV_STAGES];

  always_comb begin
    ce[DIV_STAGES-1] = !vld[DIV_STAGES-1] || out_rdy;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      ce[k] = !vld[k] || ce[k+1];
    end
  end

  always_comb begin
    row_next[0] = div_step('{rem: '0, dq: in_row}, row_pitch);
    col_next[0] = div_step('{rem: '0, dq: in_col}, col_pitch);
    for (int k = 1; k < DIV_STAGES; k++) begin
      row_next[k] = div_step(st_row[k-1], row_pitch);
      col_next[k] = div_step(st_col[k-1], col_pitch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (ce[0]) vld[0] <= in_vld;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (ce[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      st_item[0] <= in_item;
      st_row[0]  <= row_next[0];
      st_col[0]  <= col_next[0];
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (ce[k]) begin
        st_item[k] <= st_item[k-1];
        st_row[k]  <= row_next[k];
        st_col[k]  <= col_next[k];
      end
    end
  end

  assign in_rdy   = ce[0];
  assign out_vld  = vld[DIV_STAGES-1];
  assign out_item = st_item[DIV_STAGES-1];
  assign out_row  = st_row[DIV_STAGES-1];
  assign out_col  = st_col[DIV_STAGES-1];

  // a full pipe facing a stalled consumer must refuse new work
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && vld[DIV_STAGES/2] && vld[DIV_STAGES-1] && !out_rdy && !ce[1]) |-> !in_rdy)
    else $error("divider accepted while full and stalled");

endmodule

// ===== rtl/core/rcpos_corr.sv =====
// ----------------------------------------------------------------------------
// rcpos_corr
// Grid decision, correction table, gain/offset arithmetic and clamp, ending
// in the output register.
// ----------------------------------------------------------------------------
module rcpos_corr import rcpos_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [MODE_W-1:0] mode,
  input  logic              in_vld,
  output logic              in_rdy,
  input  item_t             in_item,
  input  div_t              in_row,
  input  div_t              in_col,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              corrected
);

  logic signed [ENT_W-1:0] tbl [TBL_DEPTH];

  // table stage
  logic                    vld_m;
  logic                    func_m;
  logic [PIX_W-1:0]        pix_m;
  logic                    grid_m;
  logic                    scale_m;
  logic signed [ENT_W-1:0] rdata;

  // arithmetic stage
  logic                    vld_c1;
  logic [PIX_W-1:0]        pix_c1;
  logic                    grid_c1;
  logic                    scale_c1;
  logic signed [PROD_W-1:0] prod_c1;
  logic signed [SUM_W-1:0]  sum_c1;

  logic ce_m;
  logic ce_c1;
  logic ce_out;

  logic [COORD_W-1:0] sel;
  logic [SEL_W-1:0]   sel_wide;
  logic [SEL_W-1:0]   ld_wide;
  logic               sel_ok;
  logic               ld_ok;
  logic               on_grid;

  logic signed [PROD_W-1:0] p_rnd;
  logic signed [PROD_W-1:0] p_sh;
  logic [PIX_W-1:0]         scale_val;
  logic [PIX_W-1:0]         offset_val;
  logic [PIX_W-1:0]         result;

  assign ce_out = !out_vld || out_rdy;
  assign ce_c1  = !vld_c1 || ce_out;
  assign ce_m   = !vld_m || ce_c1;
  assign in_rdy = ce_m;

  // grid test: in region, both remainders zero, selected quotient inside the table
  always_comb begin
    sel      = mode[MODE_COL] ? in_col.dq : in_row.dq;
    sel_wide = SEL_W'(sel);
    ld_wide  = SEL_W'(in_item.entry_index);
    sel_ok   = sel_wide < SEL_W'(TBL_DEPTH);
    ld_ok    = ld_wide < SEL_W'(TBL_DEPTH);
    on_grid  = in_item.in_roi && (in_row.rem == '0) && (in_col.rem == '0) && sel_ok;
  end

  always_ff @(posedge clk) begin
    if (ce_m) begin
      if (in_vld && (in_item.func == FUNC_LOAD) && ld_ok) begin
        tbl[ld_wide[TBL_AW-1:0]] <= ENT_W'($signed(in_item.entry_value));
      end
      rdata <= tbl[sel_wide[TBL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ce_m) begin
      func_m  <= in_item.func;
      pix_m   <= in_item.pixel_in;
      grid_m  <= on_grid;
      scale_m <= mode[MODE_SCALE];
    end
    if (ce_c1) begin
      pix_c1   <= pix_m;
      grid_c1  <= grid_m;
      scale_c1 <= scale_m;
      prod_c1  <= rdata * $signed({1'b0, pix_m});
      sum_c1   <= rdata + $signed({1'b0, pix_m});
    end
    if (ce_out) begin
      pixel_out <= result;
      corrected <= grid_c1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m   <= 1'b0;
      vld_c1  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (ce_m)   vld_m   <= in_vld;
      if (ce_c1)  vld_c1  <= vld_m && (func_m == FUNC_PIXEL);  // loads end here
      if (ce_out) out_vld <= vld_c1;
    end
  end

  // round, shift and clamp the product, clamp the sum, pick the result
  always_comb begin
    p_rnd = prod_c1 + PROD_W'(ROUND);
    p_sh  = p_rnd >>> FRAC_W;
    if (p_rnd[PROD_W-1]) begin
      scale_val = '0;
    end else if (p_sh[PROD_W-1:PIX_W] != '0) begin
      scale_val = '1;
    end else begin
      scale_val = p_sh[PIX_W-1:0];
    end
    if (sum_c1[SUM_W-1]) begin
      offset_val = '0;
    end else if (sum_c1[SUM_W-2:PIX_W] != '0) begin
      offset_val = '1;
    end else begin
      offset_val = sum_c1[PIX_W-1:0];
    end
    if (!grid_c1) begin
      result = pix_c1;
    end else if (scale_c1) begin
      result = scale_val;
    end else begin
      result = offset_val;
    end
  end

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (vld_m && (func_m == FUNC_LOAD) && ce_c1) |=> !vld_c1)
    else $error("load item reached the arithmetic stage");

  a_off_grid_pass: assert property (@(posedge clk) disable iff (rst)
    (vld_c1 && !grid_c1 && ce_out) |=> (pixel_out == $past(pix_c1) && !corrected))
    else $error("off-grid pixel was altered");

endmodule
